// ===== rtl/tpc_pkg.sv =====
// Package for the three-point curvature block.
// Holds the default coordinate and fraction widths and the threshold width.
// No dependencies.
package tpc_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int THR_BITS       = 32;

endpackage

// ===== rtl/three_point_curvature.sv =====
// Three-point (Menger) curvature of a 2-D point triple, fully pipelined.
// Depends on tpc_pkg for default widths and the threshold width.
//
// Takes one transaction per cycle while the output is not stalled and returns one
// result per transaction, in order. Six stages form coordinate differences,
// products, the doubled area and the normalization (the product of the three
// squared side lengths), compared against the configured threshold. Then one stage
// per curvature bit resolves floor(2*area2x*2^FRAC_BITS/sqrt(N)) by a restoring
// square-root-divide step on a residue. Each stage holds its transaction until the
// next stage frees up, so empty stages close up while the output waits and nothing
// is dropped or repeated under backpressure.
module three_point_curvature #(
  parameter int COORD_BITS = tpc_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tpc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tpc_pkg::THR_BITS-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_BITS-1:0]      in_start_x,
  input  logic signed [COORD_BITS-1:0]      in_start_y,
  input  logic signed [COORD_BITS-1:0]      in_corner_x,
  input  logic signed [COORD_BITS-1:0]      in_corner_y,
  input  logic signed [COORD_BITS-1:0]      in_end_x,
  input  logic signed [COORD_BITS-1:0]      in_end_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2*COORD_BITS:0]             out_double_area,
  output logic [FRAC_BITS+1:0]              out_curvature,
  output logic                              out_degenerate
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SQW = 2 * COORD_BITS + 1;
  localparam int AW  = 2 * COORD_BITS + 1;
  localparam int MW  = 2 * SQW;
  localparam int NW  = 3 * SQW;
  localparam int TW  = 2 * (AW + 1);
  localparam int CB  = FRAC_BITS + 2;
  localparam int W   = NW + 2 * CB + 2;
  localparam int NS  = 6 + CB;
  localparam int TB  = tpc_pkg::THR_BITS;

  logic [TB-1:0] thr_r;
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // stage 0: differences
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, ux_r, uy_r;
  logic signed [DW-1:0] sx, sy, cx, cy, ex, ey;

  assign sx = {in_start_x[COORD_BITS-1], in_start_x};
  assign sy = {in_start_y[COORD_BITS-1], in_start_y};
  assign cx = {in_corner_x[COORD_BITS-1], in_corner_x};
  assign cy = {in_corner_y[COORD_BITS-1], in_corner_y};
  assign ex = {in_end_x[COORD_BITS-1], in_end_x};
  assign ey = {in_end_y[COORD_BITS-1], in_end_y};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax_r <= sx - cx;
      ay_r <= sy - cy;
      bx_r <= ex - cx;
      by_r <= ey - cy;
      ux_r <= ex - sx;
      uy_r <= ey - sy;
    end
  end

  // stage 1: products and squares
  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [PW-1:0] qax_r, qay_r, qbx_r, qby_r, qux_r, quy_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa_r  <= PW'(ax_r) * PW'(by_r);
      pb_r  <= PW'(ay_r) * PW'(bx_r);
      qax_r <= PW'(ax_r) * PW'(ax_r);
      qay_r <= PW'(ay_r) * PW'(ay_r);
      qbx_r <= PW'(bx_r) * PW'(bx_r);
      qby_r <= PW'(by_r) * PW'(by_r);
      qux_r <= PW'(ux_r) * PW'(ux_r);
      quy_r <= PW'(uy_r) * PW'(uy_r);
    end
  end

  // stage 2: cross magnitude and squared side lengths
  logic [AW-1:0]  da2_r;
  logic [SQW-1:0] s1_r, s2_r, s3_r;
  logic signed [PW:0] crs;
  logic [PW-1:0] s1w, s2w, s3w;

  assign crs = PW'(pa_r) - PW'(pb_r);
  assign s1w = $unsigned(qax_r) + $unsigned(qay_r);
  assign s2w = $unsigned(qbx_r) + $unsigned(qby_r);
  assign s3w = $unsigned(qux_r) + $unsigned(quy_r);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      da2_r <= crs[PW] ? AW'(-crs) : AW'(crs);
      s1_r  <= SQW'(s1w);
      s2_r  <= SQW'(s2w);
      s3_r  <= SQW'(s3w);
    end
  end

  // stage 3: partial normalization, square of twice the doubled area
  logic [MW-1:0]   m_r;
  logic [SQW-1:0]  s3b_r;
  logic [TW-1:0]   tw2_r;
  logic [AW-1:0]   da3_r;
  logic [AW:0]     twod;

  assign twod = {da2_r, 1'b0};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m_r   <= MW'(s1_r) * MW'(s2_r);
      s3b_r <= s3_r;
      tw2_r <= TW'(twod) * TW'(twod);
      da3_r <= da2_r;
    end
  end

  // stage 4: normalization
  logic [NW-1:0] n4_r;
  logic [TW-1:0] tw4_r;
  logic [AW-1:0] da4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      n4_r  <= NW'(m_r) * NW'(s3b_r);
      tw4_r <= tw2_r;
      da4_r <= da3_r;
    end
  end

  // stage 5 onward: residue r = R - q^2 N, p = q N
  logic [W-1:0]   r_r  [CB+1];
  logic [W-1:0]   p_r  [CB+1];
  logic [NW-1:0]  n_r  [CB+1];
  logic [CB-1:0]  q_r  [CB+1];
  logic [AW-1:0]  da_r [CB+1];
  logic           dg_r [CB+1];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r_r[0]  <= W'(tw4_r) << (2 * FRAC_BITS);
      p_r[0]  <= '0;
      n_r[0]  <= n4_r;
      q_r[0]  <= '0;
      da_r[0] <= da4_r;
      dg_r[0] <= (n4_r <= NW'(thr_r));
    end
  end

  for (genvar j = 1; j <= CB; j++) begin : g_iter
    localparam int B = CB - j;
    logic [W-1:0] nw;
    logic [W-1:0] delta;
    logic         take;

    assign nw    = W'(n_r[j-1]);
    assign delta = (p_r[j-1] << (B + 1)) + (nw << (2 * B));
    assign take  = !dg_r[j-1] && (delta <= r_r[j-1]);

    always_ff @(posedge clk) begin
      if (en[5+j]) begin
        r_r[j]  <= take ? r_r[j-1] - delta : r_r[j-1];
        p_r[j]  <= take ? p_r[j-1] + (nw << B) : p_r[j-1];
        q_r[j]  <= take ? (q_r[j-1] | (CB'(1) << B)) : q_r[j-1];
        n_r[j]  <= n_r[j-1];
        da_r[j] <= da_r[j-1];
        dg_r[j] <= dg_r[j-1];
      end
    end
  end

  assign out_valid       = v_r[NS-1];
  assign out_double_area = da_r[CB];
  assign out_curvature   = q_r[CB];
  assign out_degenerate  = dg_r[CB];

endmodule
